// File: rtl/contiguous_segment_allocator_defines.svh
// Assertion macros used by the allocator controller (csa_ctrl)
`ifndef CONTIGUOUS_SEGMENT_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_SEGMENT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define CSA_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define CSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define CSA_ASSERT(lbl, expr, msg)
`define CSA_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/csa_pkg.sv
package csa_pkg;

  localparam int MAX_SEG = 64;
  localparam int ADDR_W  = 20;
  localparam int OWNER_W = 8;
  localparam int SIZE_W  = ADDR_W + 1;
  localparam int IDX_W   = $clog2(MAX_SEG);
  localparam int CNT_W   = $clog2(MAX_SEG + 1);

  localparam logic [CNT_W-1:0]  SEG_LIMIT = CNT_W'(MAX_SEG);
  localparam logic [SIZE_W-1:0] MEM_LIMIT = SIZE_W'(1) << ADDR_W;

  // operation codes
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_COMPACT = 2'd2;

  // placement strategies
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_BAD   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FIT    = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD       = 3'd4;

  typedef struct packed {
    logic [1:0]        op;
    logic [OWNER_W-1:0] owner_id;
    logic [SIZE_W-1:0] req_size;
    logic [1:0]        strategy;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] base_addr;
    logic [SIZE_W-1:0] allocated_total;
    logic [CNT_W-1:0]  hole_count;
    logic [SIZE_W-1:0] largest_hole;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  seg_start;
    logic [ADDR_W-1:0]  seg_end;
    logic [OWNER_W-1:0] seg_owner;
    logic               seg_in_use;
  } seg_entry_t;

  localparam int ENTRY_W = $bits(seg_entry_t);

  function automatic logic [SIZE_W-1:0] seg_size(seg_entry_t e);
    return {1'b0, e.seg_end} - {1'b0, e.seg_start} + SIZE_W'(1);
  endfunction

endpackage

// File: rtl/csa_ram.sv
module csa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/csa_ctrl.sv
`include "contiguous_segment_allocator_defines.svh"

module csa_ctrl
  import csa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_memory_size,
  output logic              res_valid,
  input  logic              res_ready,
  output out_item_t         res_item
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_COPY   = 3'd4;
  localparam logic [2:0] S_FLUSH  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic              cur_r, cur_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SIZE_W-1:0] msize_r, msize_nxt;
  in_item_t          item_r, item_nxt;
  logic [CNT_W-1:0]  rd_i_r, rd_i_nxt;
  logic              q_v_r, q_v_nxt;
  logic [IDX_W-1:0]  q_idx_r, q_idx_nxt;
  logic [CNT_W-1:0]  wr_j_r, wr_j_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  pick_r, pick_nxt;
  logic [SIZE_W-1:0] pick_sz_r, pick_sz_nxt;
  logic              mark_r, mark_nxt;
  logic              split_r, split_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [SIZE_W-1:0] alloc_r, alloc_nxt;
  logic [CNT_W-1:0]  holes_r, holes_nxt;
  logic [SIZE_W-1:0] largest_r, largest_nxt;
  seg_entry_t        pe_r, pe_nxt;
  logic              pe_v_r, pe_v_nxt;
  seg_entry_t        rem_r, rem_nxt;
  logic              rem_v_r, rem_v_nxt;
  logic [SIZE_W-1:0] pos_r, pos_nxt;

  logic              mem_we, mem_wbank, rd_en, cp_we;
  logic [IDX_W-1:0]  mem_waddr;
  seg_entry_t        mem_wdata;
  logic [ENTRY_W-1:0] q0, q1;
  seg_entry_t        q;

  // two table banks: copy passes read one and write the other
  csa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEG)) u_bank0 (
    .clk(clk), .we(mem_we && !mem_wbank), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(rd_en), .raddr(rd_i_r[IDX_W-1:0]), .rdata(q0)
  );
  csa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEG)) u_bank1 (
    .clk(clk), .we(mem_we && mem_wbank), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(rd_en), .raddr(rd_i_r[IDX_W-1:0]), .rdata(q1)
  );

  assign q = cur_r ? seg_entry_t'(q1) : seg_entry_t'(q0);

  assign cfg_ready = (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign res_valid = (state_r == S_DONE);
  assign res_item  = '{status: status_r, base_addr: base_r, allocated_total: alloc_r,
                       hole_count: holes_r, largest_hole: largest_r};

  always_comb begin
    logic [SIZE_W-1:0] clamp;
    logic [SIZE_W-1:0] sz;
    logic [SIZE_W-1:0] wsz;
    logic              fit;
    logic              freed;
    logic              split_now;
    logic              issue;
    seg_entry_t        eu;

    state_nxt = state_r;   cur_nxt = cur_r;       cnt_nxt = cnt_r;
    msize_nxt = msize_r;   item_nxt = item_r;     rd_i_nxt = rd_i_r;
    q_v_nxt = 1'b0;        q_idx_nxt = q_idx_r;   wr_j_nxt = wr_j_r;
    found_nxt = found_r;   pick_nxt = pick_r;     pick_sz_nxt = pick_sz_r;
    mark_nxt = mark_r;     split_nxt = split_r;   status_nxt = status_r;
    base_nxt = base_r;     alloc_nxt = alloc_r;   holes_nxt = holes_r;
    largest_nxt = largest_r;
    pe_nxt = pe_r;         pe_v_nxt = pe_v_r;     rem_nxt = rem_r;
    rem_v_nxt = rem_v_r;   pos_nxt = pos_r;

    mem_we = 1'b0;  mem_wbank = !cur_r;  mem_waddr = wr_j_r[IDX_W-1:0];
    mem_wdata = '0; rd_en = 1'b0;        cp_we = 1'b0;

    clamp = cfg_memory_size;
    if (clamp == '0) begin
      clamp = SIZE_W'(1);
    end
    if (clamp > MEM_LIMIT) begin
      clamp = MEM_LIMIT;
    end
    sz        = seg_size(q);
    fit       = !q.seg_in_use && (sz >= item_r.req_size);
    freed     = q.seg_in_use && (q.seg_owner == item_r.owner_id);
    eu        = q;
    eu.seg_in_use = q.seg_in_use && !freed;
    split_now = q_v_r && (item_r.op == OP_REQUEST) && split_r && (q_idx_r == pick_r);
    issue     = (rd_i_r < cnt_r) && !split_now;
    wsz       = '0;

    case (state_r)
      // write the single spanning hole after reset
      S_INIT: begin
        mem_we = 1'b1;  mem_wbank = cur_r;  mem_waddr = '0;
        mem_wdata.seg_end = ADDR_W'(msize_r - SIZE_W'(1));
        cnt_nxt = CNT_W'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_valid) begin
          msize_nxt = clamp;
          mem_we = 1'b1;  mem_wbank = cur_r;  mem_waddr = '0;
          mem_wdata.seg_end = ADDR_W'(clamp - SIZE_W'(1));
          cnt_nxt = CNT_W'(1);
        end else if (in_valid) begin
          item_nxt = in_item;
          rd_i_nxt = '0;   wr_j_nxt = '0;    found_nxt = 1'b0;
          mark_nxt = 1'b0; split_nxt = 1'b0; base_nxt = '0;
          alloc_nxt = '0;  holes_nxt = '0;   largest_nxt = '0;
          pe_v_nxt = 1'b0; rem_v_nxt = 1'b0; pos_nxt = '0;
          pick_sz_nxt = '0;
          status_nxt = ST_OK;
          state_nxt = S_COPY;
          if (in_item.op == OP_REQUEST) begin
            if (in_item.req_size == '0 || in_item.strategy == FIT_BAD) begin
              status_nxt = ST_BAD;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (in_item.op != OP_RELEASE && in_item.op != OP_COMPACT) begin
            status_nxt = ST_BAD;
          end
        end
      end
      // pick a hole, one entry per cycle
      S_SCAN: begin
        rd_en = issue;
        q_v_nxt = issue;
        q_idx_nxt = rd_i_r[IDX_W-1:0];
        if (issue) begin
          rd_i_nxt = rd_i_r + CNT_W'(1);
        end
        if (q_v_r && fit) begin
          if ((!found_r) ||
              (item_r.strategy == FIT_BEST && sz < pick_sz_r) ||
              (item_r.strategy == FIT_WORST && sz > pick_sz_r)) begin
            found_nxt = 1'b1;  pick_nxt = q_idx_r;  pick_sz_nxt = sz;
          end
        end
        if ((item_r.strategy == FIT_FIRST && q_v_r && fit && !found_r) ||
            (!issue && !q_v_r)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        rd_i_nxt = '0;
        state_nxt = S_COPY;
        if (!found_r) begin
          status_nxt = ST_NO_FIT;
        end else if (pick_sz_r == item_r.req_size) begin
          mark_nxt = 1'b1;
        end else if (cnt_r >= SEG_LIMIT) begin
          status_nxt = ST_FULL;
        end else begin
          split_nxt = 1'b1;
        end
      end
      // stream the table into the other bank, rewriting as it goes
      S_COPY: begin
        rd_en = issue;
        q_v_nxt = issue;
        q_idx_nxt = rd_i_r[IDX_W-1:0];
        if (issue) begin
          rd_i_nxt = rd_i_r + CNT_W'(1);
        end
        if (rem_v_r) begin
          cp_we = 1'b1;  mem_wdata = rem_r;  rem_v_nxt = 1'b0;
        end else if (q_v_r) begin
          case (item_r.op)
            OP_RELEASE: begin
              found_nxt = found_r || freed;
              if (pe_v_r && !pe_r.seg_in_use && !eu.seg_in_use) begin
                pe_nxt.seg_end = eu.seg_end;
              end else begin
                if (pe_v_r) begin
                  cp_we = 1'b1;  mem_wdata = pe_r;
                end
                pe_nxt = eu;  pe_v_nxt = 1'b1;
              end
            end
            OP_COMPACT: begin
              if (q.seg_in_use) begin
                cp_we = 1'b1;
                mem_wdata = q;
                mem_wdata.seg_start = pos_r[ADDR_W-1:0];
                mem_wdata.seg_end = ADDR_W'(pos_r + sz - SIZE_W'(1));
                pos_nxt = pos_r + sz;
              end
            end
            default: begin
              cp_we = 1'b1;
              mem_wdata = q;
              if ((mark_r || split_r) && q_idx_r == pick_r) begin
                mem_wdata.seg_in_use = 1'b1;
                mem_wdata.seg_owner = item_r.owner_id;
                base_nxt = q.seg_start;
                if (split_r) begin
                  mem_wdata.seg_end = ADDR_W'({1'b0, q.seg_start} + item_r.req_size
                                              - SIZE_W'(1));
                  rem_nxt = q;
                  rem_nxt.seg_start = ADDR_W'({1'b0, q.seg_start} + item_r.req_size);
                  rem_nxt.seg_in_use = 1'b0;
                  rem_v_nxt = 1'b1;
                end
              end
            end
          endcase
        end
        if (!issue && !q_v_r && !rem_v_r) begin
          state_nxt = S_FLUSH;
        end
      end
      // write out the held entry or the trailing hole
      S_FLUSH: begin
        state_nxt = S_DONE;
        if (item_r.op == OP_RELEASE) begin
          status_nxt = found_r ? ST_OK : ST_NOT_FOUND;
          if (pe_v_r) begin
            cp_we = 1'b1;  mem_wdata = pe_r;
          end
        end else if (item_r.op == OP_COMPACT) begin
          if (pos_r < msize_r && wr_j_r < SEG_LIMIT) begin
            cp_we = 1'b1;
            mem_wdata.seg_start = pos_r[ADDR_W-1:0];
            mem_wdata.seg_end = ADDR_W'(msize_r - SIZE_W'(1));
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          cnt_nxt = wr_j_r;
          cur_nxt = !cur_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // account each written entry
    if (cp_we) begin
      mem_we = 1'b1;
      wr_j_nxt = wr_j_r + CNT_W'(1);
      wsz = seg_size(mem_wdata);
      if (mem_wdata.seg_in_use) begin
        alloc_nxt = alloc_r + wsz;
      end else begin
        holes_nxt = holes_r + CNT_W'(1);
        if (wsz > largest_r) begin
          largest_nxt = wsz;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cur_r   <= 1'b0;
      cnt_r   <= CNT_W'(1);
      msize_r <= MEM_LIMIT;
      q_v_r   <= 1'b0;
      rem_v_r <= 1'b0;
      pe_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      cnt_r   <= cnt_nxt;
      msize_r <= msize_nxt;
      q_v_r   <= q_v_nxt;
      rem_v_r <= rem_v_nxt;
      pe_v_r  <= pe_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    rd_i_r    <= rd_i_nxt;
    q_idx_r   <= q_idx_nxt;
    wr_j_r    <= wr_j_nxt;
    found_r   <= found_nxt;
    pick_r    <= pick_nxt;
    pick_sz_r <= pick_sz_nxt;
    mark_r    <= mark_nxt;
    split_r   <= split_nxt;
    status_r  <= status_nxt;
    base_r    <= base_nxt;
    alloc_r   <= alloc_nxt;
    holes_r   <= holes_nxt;
    largest_r <= largest_nxt;
    pe_r      <= pe_nxt;
    rem_r     <= rem_nxt;
    pos_r     <= pos_nxt;
  end

  `CSA_ASSERT(a_copy_bound, !(cp_we && wr_j_r >= SEG_LIMIT), "copy write beyond table")
  `CSA_ASSERT_IMP(a_rem_alone, rem_v_r, !q_v_r, "remainder overlaps a read")
  `CSA_ASSERT_IMP(a_idle_count, state_r == S_IDLE, cnt_r != '0 && cnt_r <= SEG_LIMIT, "bad count")

endmodule

// File: rtl/contiguous_segment_allocator.sv
// A request runs a hole scan, a decide step and a copy pass; release, compact and bad requests
// run only the copy pass; all end with a flush. Throughput: one item at a time; a pass reads
// one table entry per cycle from the bank RAM except while a split remainder is written.
// A result waits in the output register while the next item is processed.
// Reset (rst_n low, synchronous): one hole over 1048576 bytes, written in one cycle after reset.
// A memory_size write also resets the table to one hole.
module contiguous_segment_allocator
  import csa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_memory_size
);

  logic      res_valid, res_ready;
  out_item_t res_item;
  logic      out_valid_r;
  out_item_t out_item_r;

  csa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_memory_size(cfg_memory_size),
    .res_valid(res_valid), .res_ready(res_ready), .res_item(res_item)
  );

  // hold the result until taken
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
